// ===== sv/sdrc_pkg.sv =====
// Shared types and constants for the sprite dirty-rectangle clipper.
// Used by every module of the block; depends on nothing.
package sdrc_pkg;

    localparam int RESTORE_LIST_MAX_DEF = 64;
    localparam int REFRESH_LIST_MAX_DEF = 64;

    // Input operation codes.
    localparam logic OP_FRAME_START = 1'b0;
    localparam logic OP_MOVE        = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_BLIT      = 2'd0;
    localparam logic [1:0] KIND_RESTORE   = 2'd1;
    localparam logic [1:0] KIND_REFRESH   = 2'd2;
    localparam logic [1:0] KIND_OFFSCREEN = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SCREEN_X = 2'd0;
    localparam logic [1:0] CFG_SCREEN_Y = 2'd1;
    localparam logic [1:0] CFG_SCREEN_W = 2'd2;
    localparam logic [1:0] CFG_SCREEN_H = 2'd3;

    localparam logic signed [15:0] SCREEN_X_RST = 16'sd0;
    localparam logic signed [15:0] SCREEN_Y_RST = 16'sd0;
    localparam logic [14:0]        SCREEN_W_RST = 15'd320;
    localparam logic [14:0]        SCREEN_H_RST = 15'd200;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
    } t_screen;

    typedef struct packed {
        logic               op;
        logic signed [15:0] new_x;
        logic signed [15:0] new_y;
        logic [14:0]        new_w;
        logic [14:0]        new_h;
        logic signed [15:0] old_x;
        logic signed [15:0] old_y;
        logic [14:0]        old_w;
        logic [14:0]        old_h;
    } t_item;

    typedef struct packed {
        logic [1:0]         kind;
        logic [5:0]         list_index;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic [14:0]        rect_w;
        logic [14:0]        rect_h;
        logic [14:0]        src_x;
        logic [14:0]        src_y;
    } t_result;

    // Up to three results of one move: restore, blit or offscreen, refresh.
    typedef struct packed {
        logic [2:0]    mask;
        t_result [2:0] slot;
    } t_bundle;

endpackage

// ===== sv/sdrc_clip.sv =====
// Intersection of one rectangle, given by its corner and exclusive far edges,
// with the screen rectangle. Depends on sdrc_pkg.
module sdrc_clip import sdrc_pkg::*; (
    input  t_screen            i_screen,
    input  logic signed [15:0] i_lo_x,
    input  logic signed [15:0] i_lo_y,
    input  logic signed [17:0] i_end_x,
    input  logic signed [17:0] i_end_y,
    output logic signed [15:0] o_x,
    output logic signed [15:0] o_y,
    output logic [14:0]        o_w,
    output logic [14:0]        o_h,
    output logic               o_visible
);

    logic signed [17:0] scr_end_x;
    logic signed [17:0] scr_end_y;
    logic signed [15:0] x0;
    logic signed [15:0] y0;
    logic signed [17:0] x0_ext;
    logic signed [17:0] y0_ext;
    logic signed [17:0] x1;
    logic signed [17:0] y1;
    logic signed [18:0] dx;
    logic signed [18:0] dy;

    always_comb begin
        scr_end_x = 18'(i_screen.x) + $signed({3'b000, i_screen.w});
        scr_end_y = 18'(i_screen.y) + $signed({3'b000, i_screen.h});
        x0        = (i_lo_x > i_screen.x) ? i_lo_x : i_screen.x;
        y0        = (i_lo_y > i_screen.y) ? i_lo_y : i_screen.y;
        x0_ext    = 18'(x0);
        y0_ext    = 18'(y0);
        x1        = (i_end_x < scr_end_x) ? i_end_x : scr_end_x;
        y1        = (i_end_y < scr_end_y) ? i_end_y : scr_end_y;
        dx        = 19'(x1) - 19'(x0_ext);
        dy        = 19'(y1) - 19'(y0_ext);
        o_x       = x0;
        o_y       = y0;
        o_w       = dx[14:0];
        o_h       = dy[14:0];
        o_visible = (x1 > x0_ext) && (y1 > y0_ext);
    end

endmodule

// ===== sv/sdrc_core.sv =====
// Input register, the three clip units and the list counters. Produces the
// result bundle of one item per cycle unless stalled. Depends on sdrc_pkg and sdrc_clip.
module sdrc_core import sdrc_pkg::*; #(
    parameter int RESTORE_LIST_MAX = RESTORE_LIST_MAX_DEF,
    parameter int REFRESH_LIST_MAX = REFRESH_LIST_MAX_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_screen i_screen,
    input  logic    i_valid,
    input  t_item   i_item,
    output logic    o_stall,
    input  logic    i_free,
    output logic    o_load,
    output t_bundle o_bundle
);

    localparam int RW = $clog2(RESTORE_LIST_MAX + 1);
    localparam int FW = $clog2(REFRESH_LIST_MAX + 1);

    logic          r_a_valid;
    t_item         r_a;
    logic [RW-1:0] r_restore_count;
    logic [FW-1:0] r_refresh_count;
    logic          n_a_valid;
    logic [RW-1:0] n_restore_count;
    logic [FW-1:0] n_refresh_count;

    logic               accept;
    logic               load;
    logic signed [17:0] old_end_x;
    logic signed [17:0] old_end_y;
    logic signed [17:0] new_end_x;
    logic signed [17:0] new_end_y;
    logic signed [15:0] uni_x;
    logic signed [15:0] uni_y;
    logic signed [17:0] uni_end_x;
    logic signed [17:0] uni_end_y;

    logic signed [15:0] oc_x, oc_y, nc_x, nc_y, uc_x, uc_y;
    logic [14:0]        oc_w, oc_h, nc_w, nc_h, uc_w, uc_h;
    logic               oc_vis, nc_vis, uc_vis;

    logic          restore_ok;
    logic          refresh_ok;
    logic [31:0]   restore_idx;
    logic [31:0]   refresh_idx;
    logic signed [15:0] src_dx;
    logic signed [15:0] src_dy;
    t_bundle       bundle;

    always_comb begin
        old_end_x = 18'(r_a.old_x) + $signed({3'b000, r_a.old_w});
        old_end_y = 18'(r_a.old_y) + $signed({3'b000, r_a.old_h});
        new_end_x = 18'(r_a.new_x) + $signed({3'b000, r_a.new_w});
        new_end_y = 18'(r_a.new_y) + $signed({3'b000, r_a.new_h});
        // The union is taken from the raw rectangles, empty or not.
        uni_x     = (r_a.old_x < r_a.new_x) ? r_a.old_x : r_a.new_x;
        uni_y     = (r_a.old_y < r_a.new_y) ? r_a.old_y : r_a.new_y;
        uni_end_x = (old_end_x > new_end_x) ? old_end_x : new_end_x;
        uni_end_y = (old_end_y > new_end_y) ? old_end_y : new_end_y;
    end

    sdrc_clip u_clip_old (
        .i_screen (i_screen),
        .i_lo_x   (r_a.old_x),
        .i_lo_y   (r_a.old_y),
        .i_end_x  (old_end_x),
        .i_end_y  (old_end_y),
        .o_x      (oc_x),
        .o_y      (oc_y),
        .o_w      (oc_w),
        .o_h      (oc_h),
        .o_visible(oc_vis)
    );

    sdrc_clip u_clip_new (
        .i_screen (i_screen),
        .i_lo_x   (r_a.new_x),
        .i_lo_y   (r_a.new_y),
        .i_end_x  (new_end_x),
        .i_end_y  (new_end_y),
        .o_x      (nc_x),
        .o_y      (nc_y),
        .o_w      (nc_w),
        .o_h      (nc_h),
        .o_visible(nc_vis)
    );

    sdrc_clip u_clip_uni (
        .i_screen (i_screen),
        .i_lo_x   (uni_x),
        .i_lo_y   (uni_y),
        .i_end_x  (uni_end_x),
        .i_end_y  (uni_end_y),
        .o_x      (uc_x),
        .o_y      (uc_y),
        .o_w      (uc_w),
        .o_h      (uc_h),
        .o_visible(uc_vis)
    );

    always_comb begin
        restore_ok  = oc_vis && (r_restore_count < RW'(RESTORE_LIST_MAX));
        refresh_ok  = uc_vis && (r_refresh_count < FW'(REFRESH_LIST_MAX));
        restore_idx = 32'(r_restore_count);
        refresh_idx = 32'(r_refresh_count);
        src_dx      = nc_x - r_a.new_x;
        src_dy      = nc_y - r_a.new_y;

        bundle.slot[0]            = '0;
        bundle.slot[0].kind       = KIND_RESTORE;
        bundle.slot[0].list_index = restore_idx[5:0];
        bundle.slot[0].rect_x     = oc_x;
        bundle.slot[0].rect_y     = oc_y;
        bundle.slot[0].rect_w     = oc_w;
        bundle.slot[0].rect_h     = oc_h;

        bundle.slot[1] = '0;
        if (nc_vis) begin
            bundle.slot[1].kind   = KIND_BLIT;
            bundle.slot[1].rect_x = nc_x;
            bundle.slot[1].rect_y = nc_y;
            bundle.slot[1].rect_w = nc_w;
            bundle.slot[1].rect_h = nc_h;
            bundle.slot[1].src_x  = src_dx[14:0];
            bundle.slot[1].src_y  = src_dy[14:0];
        end else begin
            bundle.slot[1].kind   = KIND_OFFSCREEN;
        end

        bundle.slot[2]            = '0;
        bundle.slot[2].kind       = KIND_REFRESH;
        bundle.slot[2].list_index = refresh_idx[5:0];
        bundle.slot[2].rect_x     = uc_x;
        bundle.slot[2].rect_y     = uc_y;
        bundle.slot[2].rect_w     = uc_w;
        bundle.slot[2].rect_h     = uc_h;

        // A frame start passes through without results.
        if (r_a.op == OP_MOVE) begin
            bundle.mask = {refresh_ok, 1'b1, restore_ok};
        end else begin
            bundle.mask = 3'b000;
        end
    end

    always_comb begin
        load            = r_a_valid && i_free;
        o_stall         = !i_rst_n || (r_a_valid && !load);
        accept          = i_valid && !o_stall;
        n_a_valid       = accept || (r_a_valid && !load);
        n_restore_count = r_restore_count;
        n_refresh_count = r_refresh_count;
        if (load) begin
            if (r_a.op == OP_FRAME_START) begin
                n_restore_count = '0;
                n_refresh_count = '0;
            end else begin
                n_restore_count = r_restore_count + RW'(restore_ok);
                n_refresh_count = r_refresh_count + FW'(refresh_ok);
            end
        end
        o_load   = load;
        o_bundle = bundle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid       <= 1'b0;
            r_restore_count <= '0;
            r_refresh_count <= '0;
        end else begin
            r_a_valid       <= n_a_valid;
            r_restore_count <= n_restore_count;
            r_refresh_count <= n_refresh_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a <= i_item;
        end
    end

endmodule

// ===== sv/sdrc_out.sv =====
// Result register: holds the bundle of one item and hands its results out
// one per transfer, lowest-numbered slot first. Depends on sdrc_pkg.
module sdrc_out import sdrc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_bundle i_bundle,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result,
    output logic    o_last
);

    logic [2:0]    r_mask;
    t_result [2:0] r_slot;
    logic [2:0]    n_mask;
    logic [2:0]    sel;
    logic [2:0]    rest;
    logic          take;

    always_comb begin
        if (r_mask[0]) begin
            sel = 3'b001;
        end else if (r_mask[1]) begin
            sel = 3'b010;
        end else if (r_mask[2]) begin
            sel = 3'b100;
        end else begin
            sel = 3'b000;
        end
        rest    = r_mask & ~sel;
        o_valid = |r_mask;
        o_last  = (rest == 3'b000);
        take    = o_valid && !i_stall;
        o_free  = !o_valid || (take && o_last);

        o_result = '0;
        for (int i = 0; i < 3; i++) begin
            if (sel[i]) begin
                o_result = r_slot[i];
            end
        end

        n_mask = take ? rest : r_mask;
        if (i_load) begin
            n_mask = i_bundle.mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= 3'b000;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_bundle.slot;
        end
    end

endmodule

// ===== sv/sprite_dirty_rect_clipper.sv =====
// Sprite dirty-rectangle clipper, top level: configuration registers, the
// clipping core and the result register. Depends on sdrc_pkg, sdrc_core, sdrc_out.
//
// Each sprite move yields, in order, a restore entry for the visible part of the
// old rectangle, a blit of the visible new rectangle (or an offscreen marker),
// and a refresh entry for the visible union of both; restore and refresh entries
// are dropped once their list count reaches its maximum, and a frame-start item
// clears both counts without producing results. Results leave one per cycle,
// unless the output is stalled, through a single output register; a move yields
// one to three results, and a new item is taken while the previous one's results
// drain. An item passes through the input register and then the result register
// before its first result is presented. The screen rectangle must only be
// rewritten while the block is idle.
module sprite_dirty_rect_clipper import sdrc_pkg::*; #(
    parameter int RESTORE_LIST_MAX = RESTORE_LIST_MAX_DEF,
    parameter int REFRESH_LIST_MAX = REFRESH_LIST_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_op,
    input  logic signed [15:0] i_new_x,
    input  logic signed [15:0] i_new_y,
    input  logic [14:0]        i_new_w,
    input  logic [14:0]        i_new_h,
    input  logic signed [15:0] i_old_x,
    input  logic signed [15:0] i_old_y,
    input  logic [14:0]        i_old_w,
    input  logic [14:0]        i_old_h,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_kind,
    output logic [5:0]         o_list_index,
    output logic signed [15:0] o_rect_x,
    output logic signed [15:0] o_rect_y,
    output logic [14:0]        o_rect_w,
    output logic [14:0]        o_rect_h,
    output logic [14:0]        o_src_x,
    output logic [14:0]        o_src_y,
    output logic               o_last
);

    t_screen r_screen;
    t_item   item;
    logic    free;
    logic    load;
    t_bundle bundle;
    t_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen.x <= SCREEN_X_RST;
            r_screen.y <= SCREEN_Y_RST;
            r_screen.w <= SCREEN_W_RST;
            r_screen.h <= SCREEN_H_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCREEN_X: r_screen.x <= i_cfg_data;
                CFG_SCREEN_Y: r_screen.y <= i_cfg_data;
                CFG_SCREEN_W: r_screen.w <= i_cfg_data[14:0];
                CFG_SCREEN_H: r_screen.h <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        item.op    = i_op;
        item.new_x = i_new_x;
        item.new_y = i_new_y;
        item.new_w = i_new_w;
        item.new_h = i_new_h;
        item.old_x = i_old_x;
        item.old_y = i_old_y;
        item.old_w = i_old_w;
        item.old_h = i_old_h;
    end

    sdrc_core #(
        .RESTORE_LIST_MAX(RESTORE_LIST_MAX),
        .REFRESH_LIST_MAX(REFRESH_LIST_MAX)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_screen(r_screen),
        .i_valid (i_valid),
        .i_item  (item),
        .o_stall (o_stall),
        .i_free  (free),
        .o_load  (load),
        .o_bundle(bundle)
    );

    sdrc_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_bundle(bundle),
        .o_free  (free),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_result(result),
        .o_last  (o_last)
    );

    assign o_kind       = result.kind;
    assign o_list_index = result.list_index;
    assign o_rect_x     = result.rect_x;
    assign o_rect_y     = result.rect_y;
    assign o_rect_w     = result.rect_w;
    assign o_rect_h     = result.rect_h;
    assign o_src_x      = result.src_x;
    assign o_src_y      = result.src_y;

endmodule

// ===== sv/sdrc_checker.sv =====
// Port-level checks for the sprite dirty-rectangle clipper, bound to the top
// level. Depends on sdrc_pkg and sprite_dirty_rect_clipper.
module sdrc_checker import sdrc_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic [1:0]         o_kind,
    input logic [5:0]         o_list_index,
    input logic signed [15:0] o_rect_x,
    input logic signed [15:0] o_rect_y,
    input logic [14:0]        o_rect_w,
    input logic [14:0]        o_rect_h,
    input logic [14:0]        o_src_x,
    input logic [14:0]        o_src_y,
    input logic               o_last
);

    // A stalled result stays in place unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_rect_x)
            && $stable(o_rect_y) && $stable(o_list_index) && $stable(o_last))
        else $error("stalled result changed");

    // A restore entry is never the last result of its move; the blit or offscreen result follows it.
    a_restore_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_RESTORE) |-> !o_last)
        else $error("restore entry closed a move");

    // The refresh entry is always the final result of its move.
    a_refresh_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_REFRESH) |-> o_last)
        else $error("refresh entry not marked last");

    a_blit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_BLIT || o_kind == KIND_OFFSCREEN)
            |-> o_list_index == 6'd0)
        else $error("list index set on a blit result");

    a_offscreen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_OFFSCREEN) |-> o_rect_x == 16'sd0
            && o_rect_y == 16'sd0 && o_rect_w == 15'd0 && o_rect_h == 15'd0
            && o_src_x == 15'd0 && o_src_y == 15'd0)
        else $error("offscreen marker carries a rectangle");

endmodule

bind sprite_dirty_rect_clipper sdrc_checker u_sdrc_checker (.*);

// ===== test/tb_sprite_dirty_rect_clipper.sv =====
// Self-checking testbench for sprite_dirty_rect_clipper: a directed stimulus table,
// then random sprite moves under several screen settings, with random back-pressure.
// Depends on sdrc_pkg and the sprite_dirty_rect_clipper RTL.
module tb_sprite_dirty_rect_clipper;
    import sdrc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT    = 400_000;
    localparam int ITEMS_PER_SET  = 58;
    localparam int N_SCREEN_SETS  = 7;
    localparam int REPORT_LIMIT   = 40;

    typedef struct packed {
        t_result res;
        logic    last;
    } t_due;

    typedef struct {
        t_item it;
        int    n_typed;   // -1: expectations come from the predictor
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic               i_op;
    logic signed [15:0] i_new_x, i_new_y, i_old_x, i_old_y;
    logic [14:0]        i_new_w, i_new_h, i_old_w, i_old_h;
    logic               o_valid;
    logic               i_stall;
    logic [1:0]         o_kind;
    logic [5:0]         o_list_index;
    logic signed [15:0] o_rect_x, o_rect_y;
    logic [14:0]        o_rect_w, o_rect_h, o_src_x, o_src_y;
    logic               o_last;

    // Predictor copy of the screen registers and list counts.
    int scr_x, scr_y, scr_w, scr_h;
    int restore_fill, refresh_fill;

    t_due rects_due[$];
    t_due typed_due[$];
    t_row rows[$];

    int spr_x, spr_y, spr_w, spr_h;
    bit tx_calm;
    int cycle_count, err_count, results_seen;
    int n_items, n_frames, n_offscreen, n_dropped;

    int screens [N_SCREEN_SETS][4] = '{
        '{0, 0, 320, 200},
        '{-32768, -32768, 32767, 32767},
        '{32767, 32767, 32767, 32767},
        '{100, -50, 0, 80},
        '{-20, 30, 640, 0},
        '{-160, -100, 320, 200},
        '{5, 7, 1, 1}
    };

    sprite_dirty_rect_clipper dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_op         (i_op),
        .i_new_x      (i_new_x),
        .i_new_y      (i_new_y),
        .i_new_w      (i_new_w),
        .i_new_h      (i_new_h),
        .i_old_x      (i_old_x),
        .i_old_y      (i_old_y),
        .i_old_w      (i_old_w),
        .i_old_h      (i_old_h),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_list_index (o_list_index),
        .o_rect_x     (o_rect_x),
        .o_rect_y     (o_rect_y),
        .o_rect_w     (o_rect_w),
        .o_rect_h     (o_rect_h),
        .o_src_x      (o_src_x),
        .o_src_y      (o_src_y),
        .o_last       (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_sprite_dirty_rect_clipper: errors");
            $finish;
        end
    end

    function automatic t_item mk_item(logic op, int nx, int ny, int nw, int nh,
                                      int ox, int oy, int ow, int oh);
        t_item it;
        it.op    = op;
        it.new_x = nx[15:0];
        it.new_y = ny[15:0];
        it.new_w = nw[14:0];
        it.new_h = nh[14:0];
        it.old_x = ox[15:0];
        it.old_y = oy[15:0];
        it.old_w = ow[14:0];
        it.old_h = oh[14:0];
        return it;
    endfunction

    function automatic t_result mk_res(logic [1:0] kind, int idx, int x, int y, int w, int h,
                                       int sx, int sy);
        t_result r;
        r.kind       = kind;
        r.list_index = idx[5:0];
        r.rect_x     = x[15:0];
        r.rect_y     = y[15:0];
        r.rect_w     = w[14:0];
        r.rect_h     = h[14:0];
        r.src_x      = sx[14:0];
        r.src_y      = sy[14:0];
        return r;
    endfunction

    // Intersect a box with the screen in wide arithmetic; true when the overlap
    // has a positive width and height.
    function automatic bit clip_box_visible(inout int x, inout int y, inout int w, inout int h);
        int x0, y0, x1, y1;
        x0 = (x > scr_x) ? x : scr_x;
        y0 = (y > scr_y) ? y : scr_y;
        x1 = (x + w < scr_x + scr_w) ? x + w : scr_x + scr_w;
        y1 = (y + h < scr_y + scr_h) ? y + h : scr_y + scr_h;
        x = x0;
        y = y0;
        w = x1 - x0;
        h = y1 - y0;
        return (x1 > x0) && (y1 > y0);
    endfunction

    function automatic void predict_clip_results(t_item it, bit keep);
        int   nx, ny, nw, nh, ox, oy, ow, oh;
        int   zx, zy, zw, zh, n;
        t_due outs [3];
        n = 0;
        if (it.op == OP_FRAME_START) begin
            restore_fill = 0;
            refresh_fill = 0;
            n_frames++;
            return;
        end
        nx = $signed(it.new_x);
        ny = $signed(it.new_y);
        nw = int'(it.new_w);
        nh = int'(it.new_h);
        ox = $signed(it.old_x);
        oy = $signed(it.old_y);
        ow = int'(it.old_w);
        oh = int'(it.old_h);

        zx = ox; zy = oy; zw = ow; zh = oh;
        if (clip_box_visible(zx, zy, zw, zh)) begin
            if (restore_fill < RESTORE_LIST_MAX_DEF) begin
                outs[n] = {mk_res(KIND_RESTORE, restore_fill, zx, zy, zw, zh, 0, 0), 1'b0};
                n++;
                restore_fill++;
            end else begin
                n_dropped++;
            end
        end

        zx = nx; zy = ny; zw = nw; zh = nh;
        if (clip_box_visible(zx, zy, zw, zh)) begin
            outs[n] = {mk_res(KIND_BLIT, 0, zx, zy, zw, zh, zx - nx, zy - ny), 1'b0};
        end else begin
            outs[n] = {mk_res(KIND_OFFSCREEN, 0, 0, 0, 0, 0, 0, 0), 1'b0};
            n_offscreen++;
        end
        n++;

        // The union is taken over the raw rectangles, empty ones included.
        zx = (ox < nx) ? ox : nx;
        zy = (oy < ny) ? oy : ny;
        zw = ((ox + ow > nx + nw) ? ox + ow : nx + nw) - zx;
        zh = ((oy + oh > ny + nh) ? oy + oh : ny + nh) - zy;
        if (clip_box_visible(zx, zy, zw, zh)) begin
            if (refresh_fill < REFRESH_LIST_MAX_DEF) begin
                outs[n] = {mk_res(KIND_REFRESH, refresh_fill, zx, zy, zw, zh, 0, 0), 1'b0};
                n++;
                refresh_fill++;
            end else begin
                n_dropped++;
            end
        end

        outs[n - 1].last = 1'b1;
        if (keep) begin
            for (int k = 0; k < n; k++) rects_due.push_back(outs[k]);
        end
    endfunction

    function automatic int near_coord(int base, int span);
        return base + $urandom_range(0, span + 96) - 48;
    endfunction

    function automatic int sprite_size();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 64);
    endfunction

    // Mostly a sprite drifting by small steps from where it last was; now and
    // then a fresh sprite near the screen, pure noise, or a frame start.
    function automatic t_item next_sprite_move();
        t_item        it;
        logic [127:0] noise;
        int           r;
        noise = {$urandom, $urandom, $urandom, $urandom};
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 79) == 0) begin
            it = noise[124:0];
            it.op = OP_FRAME_START;
            return it;
        end
        if (r < 15) begin
            it = noise[124:0];
            it.op = OP_MOVE;
        end else if (r < 32) begin
            it = mk_item(OP_MOVE, near_coord(scr_x, scr_w), near_coord(scr_y, scr_h),
                         sprite_size(), sprite_size(), near_coord(scr_x, scr_w),
                         near_coord(scr_y, scr_h), sprite_size(), sprite_size());
        end else begin
            it = mk_item(OP_MOVE, spr_x + $urandom_range(0, 16) - 8,
                         spr_y + $urandom_range(0, 16) - 8,
                         ($urandom_range(0, 9) == 0) ? sprite_size() : spr_w,
                         ($urandom_range(0, 9) == 0) ? sprite_size() : spr_h,
                         spr_x, spr_y, spr_w, spr_h);
        end
        spr_x = $signed(it.new_x);
        spr_y = $signed(it.new_y);
        spr_w = int'(it.new_w);
        spr_h = int'(it.new_h);
        return it;
    endfunction

    task automatic send_item(t_item it, int n_typed);
        int gap;
        int r;
        gap = 0;
        if ($urandom_range(0, 24) == 0) tx_calm = !tx_calm;
        if (!tx_calm) begin
            r = $urandom_range(0, 99);
            if (r >= 88) begin
                gap = $urandom_range(6, 30);
            end else if (r >= 50) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_op    = it.op;
        i_new_x = it.new_x;
        i_new_y = it.new_y;
        i_new_w = it.new_w;
        i_new_h = it.new_h;
        i_old_x = it.old_x;
        i_old_y = it.old_y;
        i_old_w = it.old_w;
        i_old_h = it.old_h;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        n_items++;
        predict_clip_results(it, n_typed < 0);
        for (int k = 0; k < n_typed; k++) rects_due.push_back(typed_due.pop_front());
        @(negedge i_clk);
    endtask

    // Frame starts give no result, so allow for one still in flight.
    task automatic wait_idle();
        i_valid = 1'b0;
        while (rects_due.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic program_screen(int sx, int sy, int sw, int sh);
        logic [1:0] regs [4];
        int         vals [4];
        regs = '{CFG_SCREEN_X, CFG_SCREEN_Y, CFG_SCREEN_W, CFG_SCREEN_H};
        vals = '{sx, sy, sw, sh};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    = 1'b1;
            i_cfg_index = regs[k];
            i_cfg_data  = vals[k][15:0];
            @(negedge i_clk);
        end
        i_cfg_we = 1'b0;
        scr_x = $signed(sx[15:0]);
        scr_y = $signed(sy[15:0]);
        scr_w = int'(sw[14:0]);
        scr_h = int'(sh[14:0]);
    endtask

    task automatic report_error(string msg);
        err_count++;
        // Keep the log readable if the block is badly broken.
        if (err_count <= REPORT_LIMIT) $display("ERROR at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want) begin
            report_error($sformatf("result %0d field %s is %h, expected %h",
                                   results_seen, name, got, want));
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_due want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (rects_due.size() == 0) begin
                report_error($sformatf("unexpected result of kind %0d", o_kind));
            end else begin
                want = rects_due.pop_front();
                check_field("kind", o_kind, want.res.kind);
                check_field("list_index", o_list_index, want.res.list_index);
                check_field("rect_x", o_rect_x, want.res.rect_x);
                check_field("rect_y", o_rect_y, want.res.rect_y);
                check_field("rect_w", o_rect_w, want.res.rect_w);
                check_field("rect_h", o_rect_h, want.res.rect_h);
                check_field("src_x", o_src_x, want.res.src_x);
                check_field("src_y", o_src_y, want.res.src_y);
                check_field("last", o_last, want.last);
            end
            results_seen++;
        end
    end

    // Result side: random stalls with calm stretches, plus long hold-offs that
    // let the block fill up while the sender keeps offering items.
    initial begin : result_sink
        int  stall_left;
        int  next_hold_at;
        bit  rx_calm;
        stall_left   = 0;
        next_hold_at = 100;
        rx_calm      = 1'b0;
        i_stall      = 1'b0;
        forever begin
            @(negedge i_clk);
            if (results_seen >= next_hold_at) begin
                next_hold_at += 400;
                stall_left = 80;
            end
            if (stall_left > 0) begin
                i_stall = 1'b1;
                stall_left--;
            end else begin
                if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
                if (!rx_calm && $urandom_range(0, 2) == 0) begin
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24)
                                                             : $urandom_range(0, 2);
                    i_stall = 1'b1;
                end else begin
                    i_stall = 1'b0;
                end
            end
        end
    end

    initial begin : stimulus
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_SCREEN_X;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_op        = OP_MOVE;
        i_new_x     = '0;
        i_new_y     = '0;
        i_new_w     = '0;
        i_new_h     = '0;
        i_old_x     = '0;
        i_old_y     = '0;
        i_old_w     = '0;
        i_old_h     = '0;
        scr_x       = int'(SCREEN_X_RST);
        scr_y       = int'(SCREEN_Y_RST);
        scr_w       = int'(SCREEN_W_RST);
        scr_h       = int'(SCREEN_H_RST);
        spr_x       = 100;
        spr_y       = 60;
        spr_w       = 16;
        spr_h       = 16;
        tx_calm     = 1'b0;

        // Directed rows run on the reset screen of 320 by 200 at the origin.
        rows.push_back('{mk_item(OP_FRAME_START, 0, 0, 0, 0, 0, 0, 0, 0), 0});
        // A sprite standing still, fully on screen: all three entries at index 0.
        rows.push_back('{mk_item(OP_MOVE, 10, 20, 16, 8, 10, 20, 16, 8), 3});
        typed_due.push_back({mk_res(KIND_RESTORE, 0, 10, 20, 16, 8, 0, 0), 1'b0});
        typed_due.push_back({mk_res(KIND_BLIT, 0, 10, 20, 16, 8, 0, 0), 1'b0});
        typed_due.push_back({mk_res(KIND_REFRESH, 0, 10, 20, 16, 8, 0, 0), 1'b1});
        // Entirely off screen: the offscreen marker alone.
        rows.push_back('{mk_item(OP_MOVE, -100, -100, 10, 10, -100, -100, 10, 10), 1});
        typed_due.push_back({mk_res(KIND_OFFSCREEN, 0, 0, 0, 0, 0, 0, 0), 1'b1});
        // Zero-sized sprite at the origin.
        rows.push_back('{mk_item(OP_MOVE, 0, 0, 0, 0, 0, 0, 0, 0), 1});
        typed_due.push_back({mk_res(KIND_OFFSCREEN, 0, 0, 0, 0, 0, 0, 0), 1'b1});
        rows.push_back('{mk_item(OP_MOVE, -32768, -32768, 32767, 32767, 300, 190, 40, 40), -1});
        rows.push_back('{mk_item(OP_MOVE, -8, -4, 32767, 32767, 32767, 32767, 32767, 32767), -1});
        rows.push_back('{mk_item(OP_MOVE, -5, -3, 20, 10, 310, 195, 20, 10), -1});
        rows.push_back('{mk_item(OP_MOVE, 0, 0, 320, 200, 0, 0, 1, 1), -1});
        rows.push_back('{mk_item(OP_MOVE, 319, 199, 1, 1, 320, 200, 1, 1), -1});
        // Both rectangles empty, but their union covers a visible square.
        rows.push_back('{mk_item(OP_MOVE, 100, 100, 0, 5, 100, 100, 5, 0), -1});
        // Union wider than 16 bits can hold.
        rows.push_back('{mk_item(OP_MOVE, -32768, 0, 32767, 50, 32767, 10, 32767, 50), -1});
        rows.push_back('{mk_item(OP_MOVE, 32767, 32767, 0, 0, -32768, -32768, 0, 0), -1});
        rows.push_back('{mk_item(OP_FRAME_START, -1, -1, 32767, 32767, -1, -1, 32767, 32767), 0});
        rows.push_back('{mk_item(OP_MOVE, -1, -1, 2, 2, 318, 198, 4, 4), -1});
        rows.push_back('{mk_item(OP_MOVE, 150, 90, 32, 32, 140, 80, 32, 32), -1});

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i]) send_item(rows[i].it, rows[i].n_typed);

        for (int s = 0; s < N_SCREEN_SETS; s++) begin
            wait_idle();
            program_screen(screens[s][0], screens[s][1], screens[s][2], screens[s][3]);
            spr_x = near_coord(scr_x, scr_w);
            spr_y = near_coord(scr_y, scr_h);
            repeat (ITEMS_PER_SET) send_item(next_sprite_move(), -1);
        end
        wait_idle();

        $display("Sent %0d items including %0d frame starts; checked %0d results.",
                 n_items, n_frames, results_seen);
        $display("%0d offscreen markers, %0d entries dropped on full lists, %0d screen settings.",
                 n_offscreen, n_dropped, N_SCREEN_SETS + 1);
        if (err_count == 0) begin
            $display("tb_sprite_dirty_rect_clipper: clean");
        end else begin
            $display("tb_sprite_dirty_rect_clipper: errors");
        end
        $finish;
    end

endmodule
